@@ src/alla_pkg.sv @@
// Shared types and constants for the auto-levels lighting adjust block.
// No dependencies.
package alla_pkg;

   localparam int ChanCount = 3;
   localparam int QShift    = 14;

   typedef enum logic [1:0] {
      CSR_BLACK     = 2'd0,
      CSR_WHITE     = 2'd1,
      CSR_SHADOW    = 2'd2,
      CSR_HIGHLIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOMAIN,
      ST_PRODUCT,
      ST_SETUP,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic measure;
      logic domain;
      logic product;
      logic setup;
      logic div_step;
      logic next_chan;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic last_chan;
   } status_type;

endpackage

@@ src/alla_datapath.sv @@
// Datapath: level registers, min/max store, domain arithmetic, serial divider.
// Depends on alla_pkg.
module alla_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  alla_pkg::cmd_type    cmd,
   output alla_pkg::status_type status,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   input  logic                 req_first_pixel,
   input  logic                 req_last_pixel,
   input  logic [7:0]           req_red_in,
   input  logic [7:0]           req_green_in,
   input  logic [7:0]           req_blue_in,
   input  logic [7:0]           req_alpha_in,
   output logic [7:0]           rsp_red_out,
   output logic [7:0]           rsp_green_out,
   output logic [7:0]           rsp_blue_out,
   output logic [7:0]           rsp_alpha_out,
   output logic                 rsp_last_out
);
   import alla_pkg::*;

   logic signed [15:0] lvl_ff [4];
   logic [7:0] min_ff [3];
   logic [7:0] max_ff [3];
   logic [7:0] pix_ff [3];
   logic [7:0] alpha_ff;
   logic last_ff;
   logic [1:0] ch_ff;
   logic [7:0] res_ff [3];

   // domain terms, scaled by 2^14
   logic signed [26:0] fb_ff, tb_ff, tw_ff, fw_ff;
   logic signed [27:0] span_ff;
   logic signed [27:0] sb_ff;    // cs - fb
   logic signed [28:0] dt_ff;    // tw - tb
   logic signed [57:0] p2_ff;

   // divider
   logic [58:0] rem_ff;
   logic [41:0] den_ff;
   logic [8:0]  quo_ff;
   logic [3:0]  cnt_ff;
   logic        zero_ff;
   logic        neg_ff;
   logic        sat_ff;

   logic [7:0] lo_w, hi_w, c_w;
   logic signed [9:0] d_w;
   logic signed [26:0] lo_s, hi_s;
   logic signed [58:0] num_w;
   logic signed [42:0] den_w;
   logic [7:0] q_w;

   always_comb begin
      lo_w = min_ff[ch_ff];
      hi_w = max_ff[ch_ff];
      c_w  = pix_ff[ch_ff];
      d_w  = $signed({2'b0, hi_w}) - $signed({2'b0, lo_w});
      lo_s = $signed({5'b0, lo_w, 14'b0});
      hi_s = $signed({5'b0, hi_w, 14'b0});
      num_w = $signed(tb_ff) * $signed(span_ff);
      num_w = num_w + 59'(p2_ff);
      den_w = $signed({span_ff, 14'b0}) + 43'sd0;
      if (quo_ff[8]) q_w = 8'hFF;
      else q_w = quo_ff[7:0];
   end

   // restoring divider: remainder compared against den << k, k = 8..0
   logic [58:0] shden_w;
   assign shden_w = 59'(den_ff) << cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff <= '{default: '0};
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= 8'hFF;
            max_ff[i] <= 8'h00;
         end
         ch_ff <= '0;
      end else begin
         if (csr_write) lvl_ff[csr_index] <= $signed(csr_data);
         if (cmd.capture) begin
            pix_ff[0] <= req_red_in;
            pix_ff[1] <= req_green_in;
            pix_ff[2] <= req_blue_in;
            alpha_ff  <= req_alpha_in;
            last_ff   <= req_last_pixel;
            ch_ff     <= '0;
         end
         if (cmd.measure) begin
            logic [7:0] px [3];
            px[0] = req_red_in; px[1] = req_green_in; px[2] = req_blue_in;
            for (int i = 0; i < 3; i++) begin
               logic [7:0] mn, mx;
               mn = req_first_pixel ? 8'hFF : min_ff[i];
               mx = req_first_pixel ? 8'h00 : max_ff[i];
               min_ff[i] <= (px[i] < mn) ? px[i] : mn;
               max_ff[i] <= (px[i] > mx) ? px[i] : mx;
            end
         end
         if (cmd.domain) begin
            fb_ff <= lo_s + 27'(d_w * lvl_ff[CSR_SHADOW]);
            fw_ff <= hi_s - 27'(d_w * lvl_ff[CSR_HIGHLIGHT]);
            tb_ff <= lo_s - 27'(d_w * lvl_ff[CSR_BLACK]);
            tw_ff <= hi_s + 27'(d_w * lvl_ff[CSR_WHITE]);
         end
         if (cmd.product) begin
            span_ff <= 28'(fw_ff) - 28'(fb_ff);
            sb_ff   <= $signed({6'b0, c_w, 14'b0}) - 28'(fb_ff);
            dt_ff   <= 29'(tw_ff) - 29'(tb_ff);
         end
         if (cmd.setup) begin
            p2_ff   <= 58'(dt_ff * sb_ff);
            zero_ff <= (span_ff == 28'sd0);
         end
         if (cmd.load_out) begin
            res_ff[ch_ff] <= zero_ff ? (tb_ff < 0 ? 8'h00 :
                             (tb_ff[26:14] > 13'd255 ? 8'hFF : tb_ff[21:14]))
                             : (neg_ff ? 8'h00 : q_w);
         end
         if (cmd.next_chan) ch_ff <= ch_ff + 2'd1;
      end
   end

   // divider setup and stepping
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (cnt_ff == 4'd15) begin
            // first step: normalize signs
            logic signed [58:0] n;
            logic signed [42:0] dd;
            n  = num_w;
            dd = den_w;
            if (dd < 0) begin
               n  = -n;
               dd = -dd;
            end
            neg_ff <= n < 0;
            rem_ff <= n;
            den_ff <= dd[41:0];
            quo_ff <= '0;
            sat_ff <= 1'b0;
            cnt_ff <= 4'd9;
         end else begin
            if (!sat_ff && cnt_ff == 4'd9 && (rem_ff >= shden_w)) begin
               sat_ff <= 1'b1;  // quotient above 511, clamp
               quo_ff <= 9'h1FF;
               cnt_ff <= 4'd0;
            end else begin
               if (rem_ff >= (59'(den_ff) << (cnt_ff - 4'd1))) begin
                  rem_ff <= rem_ff - (59'(den_ff) << (cnt_ff - 4'd1));
                  quo_ff <= quo_ff | (9'd1 << (cnt_ff - 4'd1));
               end
               cnt_ff <= cnt_ff - 4'd1;
            end
         end
      end else if (cmd.setup) begin
         cnt_ff <= 4'd15;
      end
   end

   assign status.div_done  = cmd.div_step && (cnt_ff == 4'd1 ||
                             (cnt_ff == 4'd9 && !sat_ff && rem_ff >= shden_w));
   assign status.last_chan = (ch_ff == 2'd2);

   assign rsp_red_out   = res_ff[0];
   assign rsp_green_out = res_ff[1];
   assign rsp_blue_out  = res_ff[2];
   assign rsp_alpha_out = alpha_ff;
   assign rsp_last_out  = last_ff;
endmodule

@@ src/alla_ctrl.sv @@
// Controller: sequences measure updates and the per-channel apply steps.
// Depends on alla_pkg.
module alla_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output alla_pkg::cmd_type    cmd,
   input  alla_pkg::status_type status
);
   import alla_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !req_type || !rsp_valid_ff;
            if (req_valid && req_ready) begin
               if (req_type) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_DOMAIN;
               end else begin
                  cmd.measure = 1'b1;
               end
            end
         end
         ST_DOMAIN: begin
            cmd.domain = 1'b1;
            state_in   = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            cmd.product = 1'b1;
            state_in    = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            cmd.load_out = 1'b1;
            if (status.last_chan) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.next_chan = 1'b1;
               state_in      = ST_DOMAIN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_out_only_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUTPUT))
      else $error("response raised outside output step");
   a_no_apply_while_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !cmd.capture)
      else $error("apply captured while response pending");
   a_divide_follows_setup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |=> (state_ff == ST_DIVIDE))
      else $error("setup not followed by divide");
endmodule

@@ src/auto_levels_lighting_adjust_core.sv @@
// Auto-levels contrast stretch, top level.
// Depends on alla_pkg, alla_ctrl, alla_datapath.
//
// Measure requests (req_type 0) are accepted only while idle and update the
// per-channel min/max; first_pixel restarts them. Apply requests (req_type 1)
// produce one response each. Every channel runs domain, product, setup, a
// restoring divide of two to ten steps through one shared divider and an
// output step. A further apply request waits until the response has been
// taken and is accepted from the next cycle on; measure requests are still
// accepted while a response waits. Levels are signed Q1.14 and are written
// through csr_; the user must write them only while the block is idle, which
// the block itself does not enforce. A zero-width source domain yields the
// clamped target black.
module auto_levels_lighting_adjust_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic        req_first_pixel,
   input  logic        req_last_pixel,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_alpha_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_alpha_out,
   output logic        rsp_last_out,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import alla_pkg::*;

   cmd_type    cmd;
   status_type status;

   alla_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .rsp_valid, .rsp_ready, .cmd, .status
   );

   alla_datapath u_dp (
      .clock, .reset, .cmd, .status, .csr_write, .csr_index, .csr_data,
      .req_first_pixel, .req_last_pixel, .req_red_in, .req_green_in,
      .req_blue_in, .req_alpha_in, .rsp_red_out, .rsp_green_out,
      .rsp_blue_out, .rsp_alpha_out, .rsp_last_out
   );
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for auto_levels_lighting_adjust_core.
// Depends on alla_pkg and the core RTL; runs directed and random frames through it.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import alla_pkg::*;

   // request type codes
   localparam bit PIX_MEASURE = 1'b0;
   localparam bit PIX_APPLY   = 1'b1;
   // margin after the last response before idle-only actions
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = 1'b0;
   logic        req_first_pixel = 1'b0;
   logic        req_last_pixel = 1'b0;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic [7:0]  req_alpha_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [7:0]  rsp_alpha_out;
   logic        rsp_last_out;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   auto_levels_lighting_adjust_core DUT (.*);

   always #5 clock = ~clock;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } pixel_out_type;

   pixel_out_type pixel_q[$];

   // predictor state: levels as signed values, measured per-channel bounds
   longint lvl_black, lvl_white, lvl_shadow, lvl_highlight;
   logic [7:0] ch_min [3];
   logic [7:0] ch_max [3];

   int  mismatches = 0;
   int  cycles = 0;
   bit  quiet = 1'b0;   // no idling on either side while set

   // exact remap of one channel, floor then clamp to 0..255
   function automatic logic [7:0] stretch(logic [7:0] lo, logic [7:0] hi, logic [7:0] c);
      longint d, fb, fw, tb, tw, cs, span, num, den, q;
      d    = longint'(hi) - longint'(lo);
      fb   = longint'(lo) * 16384 + d * lvl_shadow;
      fw   = longint'(hi) * 16384 - d * lvl_highlight;
      tb   = longint'(lo) * 16384 - d * lvl_black;
      tw   = longint'(hi) * 16384 + d * lvl_white;
      cs   = longint'(c) * 16384;
      span = fw - fb;
      if (span == 0) begin
         num = tb;
         den = 16384;
      end else begin
         num = tb * span + (tw - tb) * (cs - fb);
         den = 16384 * span;
         if (den < 0) begin
            num = -num;
            den = -den;
         end
      end
      if (num < 0) return 8'd0;
      q = num / den;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // update the predictor for one accepted request
   task automatic predict(bit kind, bit first, bit last, logic [7:0] px [3], logic [7:0] a);
      pixel_out_type e;
      if (kind == PIX_MEASURE) begin
         for (int i = 0; i < 3; i++) begin
            if (first) begin
               ch_min[i] = 8'd255;
               ch_max[i] = 8'd0;
            end
            if (px[i] < ch_min[i]) ch_min[i] = px[i];
            if (px[i] > ch_max[i]) ch_max[i] = px[i];
         end
      end else begin
         e.red   = stretch(ch_min[0], ch_max[0], px[0]);
         e.green = stretch(ch_min[1], ch_max[1], px[1]);
         e.blue  = stretch(ch_min[2], ch_max[2], px[2]);
         e.alpha = a;
         e.last  = last;
         pixel_q.push_back(e);
      end
   endtask

   // send one request; entered and left on a rising edge, valid left high
   task automatic send_pixel(bit kind, bit first, bit last,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      logic [7:0] px [3];
      if (!quiet && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_first_pixel <= first;
      req_last_pixel  <= last;
      req_red_in      <= r;
      req_green_in    <= g;
      req_blue_in     <= b;
      req_alpha_in    <= a;
      do @(posedge clock); while (!req_ready);
      px[0] = r;
      px[1] = g;
      px[2] = b;
      predict(kind, first, last, px, a);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // level write, only called while idle; the caller drops the write enable
   task automatic write_level(csr_index_type idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         CSR_BLACK:     lvl_black     = longint'($signed(val));
         CSR_WHITE:     lvl_white     = longint'($signed(val));
         CSR_SHADOW:    lvl_shadow    = longint'($signed(val));
         CSR_HIGHLIGHT: lvl_highlight = longint'($signed(val));
         default: ;
      endcase
   endtask

   task automatic set_levels(logic [15:0] bl, logic [15:0] wh, logic [15:0] sh,
                             logic [15:0] hl);
      wait_idle();
      write_level(CSR_BLACK, bl);
      write_level(CSR_WHITE, wh);
      write_level(CSR_SHADOW, sh);
      write_level(CSR_HIGHLIGHT, hl);
      csr_write <= 1'b0;
   endtask

   function automatic logic [7:0] rnd8();
      return 8'($urandom);
   endfunction

   // apply before any measure uses the reset bounds
   task automatic test_unmeasured();
      send_pixel(PIX_APPLY, 1'b0, 1'b0, 8'd0, 8'd128, 8'd255, 8'd0);
      send_pixel(PIX_APPLY, 1'b1, 1'b1, 8'd255, 8'd0, 8'd77, 8'd255);
   endtask

   // extremes, zero-width domain, stray flags
   task automatic test_directed();
      // full-range measure, last flag on a measure pixel
      send_pixel(PIX_MEASURE, 1'b1, 1'b0, 8'd0, 8'd255, 8'd10, 8'h5a);
      send_pixel(PIX_MEASURE, 1'b0, 1'b1, 8'd255, 8'd0, 8'd200, 8'ha5);
      send_pixel(PIX_APPLY, 1'b0, 1'b0, 8'd0, 8'd0, 8'd10, 8'd1);
      send_pixel(PIX_APPLY, 1'b1, 1'b0, 8'd255, 8'd255, 8'd200, 8'd2);
      send_pixel(PIX_APPLY, 1'b0, 1'b1, 8'd128, 8'd1, 8'd254, 8'd3);
      // single-pixel measure: min equals max, zero-width source
      send_pixel(PIX_MEASURE, 1'b1, 1'b1, 8'd0, 8'd255, 8'd90, 8'd0);
      send_pixel(PIX_APPLY, 1'b0, 1'b0, 8'd0, 8'd255, 8'd90, 8'd4);
      send_pixel(PIX_APPLY, 1'b0, 1'b1, 8'd255, 8'd0, 8'd91, 8'd5);
      // shadow plus highlight of one full range collapses the source domain
      set_levels(16'sd0, 16'sd0, 16'sd8192, 16'sd8192);
      send_pixel(PIX_MEASURE, 1'b1, 1'b0, 8'd20, 8'd0, 8'd100, 8'd0);
      send_pixel(PIX_MEASURE, 1'b0, 1'b1, 8'd220, 8'd255, 8'd101, 8'd0);
      send_pixel(PIX_APPLY, 1'b0, 1'b0, 8'd20, 8'd0, 8'd100, 8'd6);
      send_pixel(PIX_APPLY, 1'b0, 1'b1, 8'd219, 8'd255, 8'd101, 8'd7);
      // extreme level values, positive and negative, and raw out-of-range codes
      set_levels(16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384);
      send_pixel(PIX_APPLY, 1'b0, 1'b0, 8'd0, 8'd128, 8'd255, 8'd8);
      send_pixel(PIX_APPLY, 1'b0, 1'b1, 8'd100, 8'd200, 8'd150, 8'd9);
      set_levels(-16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384);
      send_pixel(PIX_APPLY, 1'b0, 1'b0, 8'd0, 8'd128, 8'd255, 8'd10);
      send_pixel(PIX_APPLY, 1'b0, 1'b1, 8'd100, 8'd200, 8'd150, 8'd11);
      set_levels(16'h7fff, 16'h8000, 16'hffff, 16'h8000);
      send_pixel(PIX_APPLY, 1'b0, 1'b0, 8'd30, 8'd60, 8'd90, 8'd12);
      send_pixel(PIX_APPLY, 1'b0, 1'b1, 8'd200, 8'd40, 8'd101, 8'd13);
   endtask

   // random frames: measure pass then apply pass, with some noise mixed in
   task automatic test_random_frames(int n_items);
      int sent, m, k;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            // noise: arbitrary flags
            send_pixel(1'($urandom), 1'($urandom), 1'($urandom),
                       rnd8(), rnd8(), rnd8(), rnd8());
            sent++;
         end else begin
            m = $urandom_range(6, 1);
            for (int i = 0; i < m; i++)
               send_pixel(PIX_MEASURE, i == 0, i == m - 1, rnd8(), rnd8(), rnd8(), rnd8());
            k = $urandom_range(8, 1);
            for (int i = 0; i < k; i++)
               send_pixel(PIX_APPLY, 1'($urandom), i == k - 1, rnd8(), rnd8(), rnd8(), rnd8());
            sent += m + k;
         end
      end
   endtask

   function automatic logic [15:0] rnd_level();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'($urandom_range(32768) - 16384);
   endfunction

   task automatic test_level_sweep();
      for (int p = 0; p < 10; p++) begin
         case (p)
            0: set_levels(16'sd0, 16'sd0, 16'sd0, 16'sd0);
            1: set_levels(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
            2: set_levels(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
            3: set_levels(16'sd1638, 16'sd1638, 16'sd820, 16'sd820);
            default: set_levels(rnd_level(), rnd_level(), rnd_level(), rnd_level());
         endcase
         quiet = (p == 4);
         test_random_frames(160);
         quiet = 1'b0;
         if (p == 6) begin
            // sender holds off until the pipeline has fully drained
            wait_idle();
         end
      end
   endtask

   // result sink: random back-pressure, compare against the oldest prediction
   always @(posedge clock) begin
      pixel_out_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: r=%0d g=%0d b=%0d a=%0d last=%0b",
                        rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out, rsp_last_out);
         end else begin
            e = pixel_q.pop_front();
            if (rsp_red_out !== e.red || rsp_green_out !== e.green ||
                rsp_blue_out !== e.blue || rsp_alpha_out !== e.alpha ||
                rsp_last_out !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp r=%0d g=%0d b=%0d a=%0d last=%0b, ",
                            "got r=%0d g=%0d b=%0d a=%0d last=%0b"},
                           e.red, e.green, e.blue, e.alpha, e.last,
                           rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out,
                           rsp_last_out);
            end
         end
      end
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      lvl_black = 0;
      lvl_white = 0;
      lvl_shadow = 0;
      lvl_highlight = 0;
      for (int i = 0; i < 3; i++) begin
         ch_min[i] = 8'd255;
         ch_max[i] = 8'd0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unmeasured();
      test_directed();
      test_level_sweep();
      wait_idle();
      if (mismatches == 0 && pixel_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
